FILE: hdl/spsq_pkg.sv
package spsq_pkg;

	localparam int unsigned WEIGHT_W   = 4;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned PRIORITY_W = 4;
	localparam int unsigned SPEED_W    = 12;
	localparam int unsigned KEY_W      = 12;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned OCC_W      = 5;

	localparam logic [MODE_W-1:0] MODE_PRIORITY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SPEED    = 2'd1;

	localparam logic ACT_INSERT   = 1'b0;
	localparam logic ACT_DISPATCH = 1'b1;

	typedef struct packed {
		logic [WEIGHT_W-1:0]   weight;
		logic [KIND_W-1:0]     kind;
		logic [PRIORITY_W-1:0] prio;
		logic [SPEED_W-1:0]    speed;
	} job_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		job_t             job;
	} cand_t;

	typedef struct packed {
		logic              ins;
		logic              del;
		logic [MODE_W-1:0] mode;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

FILE: hdl/spsq_cell.sv
module spsq_cell import spsq_pkg::*; #(
	parameter int unsigned IDX_W    = 4,
	parameter int unsigned CNT_W    = 5,
	parameter int unsigned CELL_IDX = 0
) (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [CNT_W-1:0] count,
	input  logic [IDX_W-1:0] del_idx,
	input  job_t             new_job,
	input  job_t             next_job,
	input  cand_t            cand_in,
	input  logic [IDX_W-1:0] cand_idx_in,
	output cand_t            cand_out,
	output logic [IDX_W-1:0] cand_idx_out,
	output job_t             job
);

	job_t             job_q;
	cand_t            cand_s1;
	logic [IDX_W-1:0] cand_idx_s1;
	logic             own_valid;
	logic [KEY_W-1:0] key;
	logic             take;

	assign own_valid = count > CNT_W'(CELL_IDX);

	always_comb begin
		case (ctrl.mode)
			MODE_PRIORITY: key = KEY_W'(job_q.prio);
			MODE_SPEED:    key = KEY_W'(job_q.speed);
			default:       key = '0;
		endcase
	end

	assign take = own_valid && (!cand_in.valid || key > cand_in.key);

	// hold the best request seen so far and hand it on
	always_ff @(posedge clk) begin
		if (take) begin
			cand_s1.valid <= 1'b1;
			cand_s1.key   <= key;
			cand_s1.job   <= job_q;
			cand_idx_s1   <= IDX_W'(CELL_IDX);
		end else begin
			cand_s1     <= cand_in;
			cand_idx_s1 <= cand_idx_in;
		end
	end

	// append at the tail, close the gap on removal
	always_ff @(posedge clk) begin
		if (ctrl.ins && count == CNT_W'(CELL_IDX)) begin
			job_q <= new_job;
		end else if (ctrl.del && IDX_W'(CELL_IDX) >= del_idx) begin
			job_q <= next_job;
		end
	end

	assign cand_out     = cand_s1;
	assign cand_idx_out = cand_idx_s1;
	assign job          = job_q;

endmodule

FILE: hdl/stable_priority_select_queue_top.sv
// Flow: an insert request goes from acceptance to ST_DONE, where its result
// is registered once the output is free; a dispatch request first passes
// ST_SCAN, the selection wave moving one cell per cycle along the QUEUE_DEPTH cells.
// Throughput: one request at a time; a new request is taken once the previous
// result is registered, even while that result still waits on the output.
// Reset: arst_n clears the job count, select mode and control; no clearing pass.
module stable_priority_select_queue_top import spsq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [MODE_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [WEIGHT_W-1:0]   job_weight,
	input  logic [KIND_W-1:0]     job_kind,
	input  logic [PRIORITY_W-1:0] job_priority,
	input  logic [SPEED_W-1:0]    job_speed,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  found,
	output logic                  overflow,
	output logic [WEIGHT_W-1:0]   out_weight,
	output logic [KIND_W-1:0]     out_kind,
	output logic [PRIORITY_W-1:0] out_priority,
	output logic [SPEED_W-1:0]    out_speed,
	output logic [OCC_W-1:0]      occupancy
);

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	state_t            state_q, state_d;
	logic [MODE_W-1:0] mode_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [IDX_W-1:0]  scan_q;
	logic              act_q;
	job_t              new_job_q;
	logic              accept;
	logic              commit;
	logic              full;
	logic              empty;
	cell_ctrl_t        ctrl;

	logic              out_valid_q;
	logic              found_q;
	logic              overflow_q;
	job_t              out_job_q;
	logic [OCC_W-1:0]  occupancy_q;

	cand_t             cand [QUEUE_DEPTH+1];
	logic [IDX_W-1:0]  cand_idx [QUEUE_DEPTH+1];
	job_t              jobs [QUEUE_DEPTH];

	assign cfg_ready = 1'b1;
	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty     = count_q == '0;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (action == ACT_DISPATCH) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_q == IDX_W'(QUEUE_DEPTH - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_q <= scan_q + 1'b1;
		end else begin
			scan_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q              <= action;
			new_job_q.weight   <= job_weight;
			new_job_q.kind     <= job_kind;
			new_job_q.prio     <= job_priority;
			new_job_q.speed    <= job_speed;
		end
	end

	always_comb begin
		ctrl.mode = mode_q;
		ctrl.ins  = commit && act_q == ACT_INSERT && !full;
		ctrl.del  = commit && act_q == ACT_DISPATCH && !empty;
		count_d   = count_q;
		if (ctrl.ins) begin
			count_d = count_q + 1'b1;
		end else if (ctrl.del) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign cand[0]     = '0;
	assign cand_idx[0] = '0;

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		job_t next_job;
		if (k == QUEUE_DEPTH - 1) begin : g_last
			assign next_job = jobs[k];
		end else begin : g_mid
			assign next_job = jobs[k+1];
		end
		spsq_cell #(
			.IDX_W    (IDX_W),
			.CNT_W    (CNT_W),
			.CELL_IDX (k)
		) u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.count        (count_q),
			.del_idx      (cand_idx[QUEUE_DEPTH]),
			.new_job      (new_job_q),
			.next_job     (next_job),
			.cand_in      (cand[k]),
			.cand_idx_in  (cand_idx[k]),
			.cand_out     (cand[k+1]),
			.cand_idx_out (cand_idx[k+1]),
			.job          (jobs[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			found_q     <= ctrl.del;
			overflow_q  <= act_q == ACT_INSERT && full;
			out_job_q   <= ctrl.del ? cand[QUEUE_DEPTH].job : '0;
			occupancy_q <= OCC_W'(count_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign overflow     = overflow_q;
	assign out_weight   = out_job_q.weight;
	assign out_kind     = out_job_q.kind;
	assign out_priority = out_job_q.prio;
	assign out_speed    = out_job_q.speed;
	assign occupancy    = occupancy_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("job count beyond queue depth");

	a_count_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_DONE |=> $stable(count_q))
		else $error("job count moved outside commit");

	a_found_excl_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(found_q && overflow_q))
		else $error("result both found and overflow");

	a_found_has_candidate: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.del |-> cand[QUEUE_DEPTH].valid)
		else $error("dispatch without a selected job");
`endif

endmodule
